// File: src/r2y_pkg.sv
// shared types and fixed-point constants for the rgb to 10-bit yuv converter
package r2y_pkg;

  localparam int COEF_W = 27;
  localparam int PROD_W = 35;
  localparam int ACC_W  = 38;
  localparam int FRAC_W = 24;
  localparam int CODE_W = 10;
  localparam int ADDR_W = 4;

  localparam longint unsigned FRAC_ONE = 64'd16777216;
  localparam longint unsigned DEN_UV   = 64'd100000000000;

  // luma weights rounded up, chroma weights rounded to nearest
  localparam longint unsigned KY_R_L =
    (64'd299 * 64'd876 * FRAC_ONE + 64'd254999) / 64'd255000;
  localparam longint unsigned KY_G_L =
    (64'd587 * 64'd876 * FRAC_ONE + 64'd254999) / 64'd255000;
  localparam longint unsigned KY_B_L =
    (64'd114 * 64'd876 * FRAC_ONE + 64'd254999) / 64'd255000;
  localparam longint unsigned KU_R_L =
    (64'd299 * 64'd493 * 64'd11447 * 64'd35 * FRAC_ONE + DEN_UV / 64'd2) / DEN_UV;
  localparam longint unsigned KU_G_L =
    (64'd587 * 64'd493 * 64'd11447 * 64'd35 * FRAC_ONE + DEN_UV / 64'd2) / DEN_UV;
  localparam longint unsigned KV_G_L =
    (64'd587 * 64'd877 * 64'd8133 * 64'd35 * FRAC_ONE + DEN_UV / 64'd2) / DEN_UV;
  localparam longint unsigned KV_B_L =
    (64'd114 * 64'd877 * 64'd8133 * 64'd35 * FRAC_ONE + DEN_UV / 64'd2) / DEN_UV;

  localparam logic [COEF_W-1:0] KY_R = COEF_W'(KY_R_L);
  localparam logic [COEF_W-1:0] KY_G = COEF_W'(KY_G_L);
  localparam logic [COEF_W-1:0] KY_B = COEF_W'(KY_B_L);
  localparam logic [COEF_W-1:0] KU_R = COEF_W'(KU_R_L);
  localparam logic [COEF_W-1:0] KU_G = COEF_W'(KU_G_L);
  // grey pixels cancel exactly
  localparam logic [COEF_W-1:0] KU_B = COEF_W'(KU_R_L + KU_G_L);
  localparam logic [COEF_W-1:0] KV_G = COEF_W'(KV_G_L);
  localparam logic [COEF_W-1:0] KV_B = COEF_W'(KV_B_L);
  localparam logic [COEF_W-1:0] KV_R = COEF_W'(KV_G_L + KV_B_L);

  localparam logic [CODE_W-1:0] LUMA_BLACK = 10'd64;
  localparam logic [CODE_W-1:0] LUMA_WHITE = 10'd940;
  localparam logic [CODE_W-1:0] UV_ZERO    = 10'd512;
  localparam logic [CODE_W-1:0] CODE_MAX   = 10'd1023;

  localparam logic signed [ACC_W-1:0] Y_OFS  = ACC_W'(64'd64 * FRAC_ONE);
  localparam logic signed [ACC_W-1:0] UV_OFS = ACC_W'(64'd512 * FRAC_ONE);

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_WHITE  = 2'd1;
  localparam logic [1:0] REG_BLACK  = 2'd2;

  localparam logic [9:0] WHITE_RST = 10'd747;
  localparam logic [9:0] BLACK_RST = 10'd10;

  typedef struct packed {
    logic       enable;
    logic [9:0] white;
    logic [9:0] black;
  } cfg_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       line_end;
  } pix_t;

  typedef struct packed {
    logic [PROD_W-1:0] y_r;
    logic [PROD_W-1:0] y_g;
    logic [PROD_W-1:0] y_b;
    logic [PROD_W-1:0] u_r;
    logic [PROD_W-1:0] u_g;
    logic [PROD_W-1:0] u_b;
    logic [PROD_W-1:0] v_r;
    logic [PROD_W-1:0] v_g;
    logic [PROD_W-1:0] v_b;
    logic              line_end;
  } prod_t;

endpackage

// File: src/r2y_snap.sv
// stage 1: near-white and near-black snapping of the incoming pixel
module r2y_snap (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  input  r2y_pkg::pix_t  pix_i,
  input  r2y_pkg::cfg_t  cfg_i,
  output logic           valid_o,
  output r2y_pkg::pix_t  pix_o
);
  import r2y_pkg::*;

  logic [9:0] sum;
  logic       valid_r;
  pix_t       pix_r;
  pix_t       pix_nxt;

  assign sum = 10'(pix_i.blue) + 10'(pix_i.green) + 10'(pix_i.red);

  always_comb begin
    pix_nxt = pix_i;
    if (cfg_i.enable) begin
      if (sum > cfg_i.white) begin
        pix_nxt.blue  = 8'hFF;
        pix_nxt.green = 8'hFF;
        pix_nxt.red   = 8'hFF;
      end
      // black snap wins when both thresholds hit
      if (sum < cfg_i.black) begin
        pix_nxt.blue  = 8'h00;
        pix_nxt.green = 8'h00;
        pix_nxt.red   = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

  assign valid_o = valid_r;
  assign pix_o   = pix_r;

  a_black_snap: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_i && cfg_i.enable && (sum < cfg_i.black)) |=>
    (pix_r.blue == 8'h00 && pix_r.green == 8'h00 && pix_r.red == 8'h00))
    else $error("near-black pixel not snapped to black");

endmodule

// File: src/r2y_mult.sv
// stage 2: the nine coefficient products
module r2y_mult (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  input  r2y_pkg::pix_t  pix_i,
  output logic           valid_o,
  output r2y_pkg::prod_t prod_o
);
  import r2y_pkg::*;

  logic  valid_r;
  prod_t prod_r;
  prod_t prod_nxt;

  always_comb begin
    prod_nxt.y_r      = PROD_W'(KY_R) * PROD_W'(pix_i.red);
    prod_nxt.y_g      = PROD_W'(KY_G) * PROD_W'(pix_i.green);
    prod_nxt.y_b      = PROD_W'(KY_B) * PROD_W'(pix_i.blue);
    prod_nxt.u_r      = PROD_W'(KU_R) * PROD_W'(pix_i.red);
    prod_nxt.u_g      = PROD_W'(KU_G) * PROD_W'(pix_i.green);
    prod_nxt.u_b      = PROD_W'(KU_B) * PROD_W'(pix_i.blue);
    prod_nxt.v_r      = PROD_W'(KV_R) * PROD_W'(pix_i.red);
    prod_nxt.v_g      = PROD_W'(KV_G) * PROD_W'(pix_i.green);
    prod_nxt.v_b      = PROD_W'(KV_B) * PROD_W'(pix_i.blue);
    prod_nxt.line_end = pix_i.line_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign valid_o = valid_r;
  assign prod_o  = prod_r;

endmodule

// File: src/r2y_sum.sv
// stages 3 and 4: sum of products with offset, then clamp to 10-bit codes
module r2y_sum (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         valid_i,
  input  r2y_pkg::prod_t               prod_i,
  output logic                         valid_o,
  output logic [r2y_pkg::CODE_W-1:0]   luma_o,
  output logic [r2y_pkg::CODE_W-1:0]   blue_diff_o,
  output logic [r2y_pkg::CODE_W-1:0]   red_diff_o,
  output logic                         line_last_o
);
  import r2y_pkg::*;

  logic signed [ACC_W-1:0] y_acc_r, u_acc_r, v_acc_r;
  logic signed [ACC_W-1:0] y_acc_nxt, u_acc_nxt, v_acc_nxt;
  logic                    acc_valid_r;
  logic                    acc_last_r;
  logic                    out_valid_r;
  logic                    out_last_r;
  logic [CODE_W-1:0]       luma_r, blue_diff_r, red_diff_r;

  function automatic logic [CODE_W-1:0] to_code(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-FRAC_W-1:0] whole;
    whole = acc[ACC_W-1:FRAC_W];
    if (acc < 0) begin
      to_code = '0;
    end else if (whole > (ACC_W-FRAC_W)'(CODE_MAX)) begin
      to_code = CODE_MAX;
    end else begin
      to_code = whole[CODE_W-1:0];
    end
  endfunction

  always_comb begin
    y_acc_nxt = $signed(ACC_W'(prod_i.y_r)) + $signed(ACC_W'(prod_i.y_g))
              + $signed(ACC_W'(prod_i.y_b)) + Y_OFS;
    u_acc_nxt = $signed(ACC_W'(prod_i.u_b)) - $signed(ACC_W'(prod_i.u_r))
              - $signed(ACC_W'(prod_i.u_g)) + UV_OFS;
    v_acc_nxt = $signed(ACC_W'(prod_i.v_r)) - $signed(ACC_W'(prod_i.v_g))
              - $signed(ACC_W'(prod_i.v_b)) + UV_OFS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_valid_r <= valid_i;
      out_valid_r <= acc_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    y_acc_r     <= y_acc_nxt;
    u_acc_r     <= u_acc_nxt;
    v_acc_r     <= v_acc_nxt;
    acc_last_r  <= prod_i.line_end;
    luma_r      <= to_code(y_acc_r);
    blue_diff_r <= to_code(u_acc_r);
    red_diff_r  <= to_code(v_acc_r);
    out_last_r  <= acc_last_r;
  end

  assign valid_o     = out_valid_r;
  assign luma_o      = luma_r;
  assign blue_diff_o = blue_diff_r;
  assign red_diff_o  = red_diff_r;
  assign line_last_o = out_last_r;

endmodule

// File: src/rgb_to_yuv_10bit_converter_top.sv
// top level of the rgb to 10-bit yuv converter with its register port
// Converts one 8-bit rgb pixel per clock into 10-bit video-level Y, U and V.
// A request is taken whenever start is high; busy is never raised, so a new
// pixel may follow in every cycle. Each result appears on the out_ ports with
// out_valid once it has passed the registered stages for the white/black snap,
// the nine coefficient multiplies, the sums and the clamp to 10-bit codes.
// The receiver cannot hold results off.
// Registers (byte address): 0x0 threshold_enable, 0x4 white_threshold,
// 0x8 black_threshold; write them only while no pixel is in flight.
module rgb_to_yuv_10bit_converter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [7:0]                    in_blue,
  input  logic [7:0]                    in_green,
  input  logic [7:0]                    in_red,
  input  logic                          in_line_end,
  output logic                          out_valid,
  output logic [r2y_pkg::CODE_W-1:0]    out_luma,
  output logic [r2y_pkg::CODE_W-1:0]    out_blue_diff,
  output logic [r2y_pkg::CODE_W-1:0]    out_red_diff,
  output logic                          out_line_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [r2y_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import r2y_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;
  pix_t       in_pix;
  logic       accept;
  logic       s1_valid;
  pix_t       s1_pix;
  logic       s2_valid;
  prod_t      s2_prod;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign accept  = start && !busy;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable <= 1'b1;
      cfg_r.white  <= WHITE_RST;
      cfg_r.black  <= BLACK_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ENABLE: cfg_r.enable <= pwdata[0];
        REG_WHITE:  cfg_r.white  <= pwdata[9:0];
        REG_BLACK:  cfg_r.black  <= pwdata[9:0];
        default:    cfg_r        <= cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ENABLE: prdata = {31'd0, cfg_r.enable};
      REG_WHITE:  prdata = {22'd0, cfg_r.white};
      REG_BLACK:  prdata = {22'd0, cfg_r.black};
      default:    prdata = '0;
    endcase
  end

  assign in_pix.blue     = in_blue;
  assign in_pix.green    = in_green;
  assign in_pix.red      = in_red;
  assign in_pix.line_end = in_line_end;

  r2y_snap u_snap (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (accept),
    .pix_i   (in_pix),
    .cfg_i   (cfg_r),
    .valid_o (s1_valid),
    .pix_o   (s1_pix)
  );

  r2y_mult u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid),
    .pix_i   (s1_pix),
    .valid_o (s2_valid),
    .prod_o  (s2_prod)
  );

  r2y_sum u_sum (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid_i     (s2_valid),
    .prod_i      (s2_prod),
    .valid_o     (out_valid),
    .luma_o      (out_luma),
    .blue_diff_o (out_blue_diff),
    .red_diff_o  (out_red_diff),
    .line_last_o (out_line_last)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_valid)
    else $error("request did not produce a result four cycles later");

  a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_luma >= LUMA_BLACK && out_luma <= LUMA_WHITE))
    else $error("luma outside video levels");

  a_grey_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && s1_pix.red == s1_pix.green && s1_pix.green == s1_pix.blue)
    |-> ##3 (out_blue_diff == UV_ZERO && out_red_diff == UV_ZERO))
    else $error("grey pixel gave nonzero color difference");

endmodule

// File: tb/tb_rgb_to_yuv_10bit_converter_top.sv
// self-checking testbench for the rgb to 10-bit yuv converter top level
module tb_rgb_to_yuv_10bit_converter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import r2y_pkg::*;

  localparam int PIPE_DEPTH = 4;
  localparam int CYCLE_LIMIT = 100000;
  localparam int SUM_MAX = 765;

  // 24 fractional bits; luma weights rounded up, chroma weights to nearest
  localparam longint ONE24 = 64'd16777216;
  localparam longint CY_R = (64'd299 * 64'd876 * 64'd16777216 + 64'd254999) / 64'd255000;
  localparam longint CY_G = (64'd587 * 64'd876 * 64'd16777216 + 64'd254999) / 64'd255000;
  localparam longint CY_B = (64'd114 * 64'd876 * 64'd16777216 + 64'd254999) / 64'd255000;
  localparam longint CU_R =
    (64'd299 * 64'd493 * 64'd11447 * 64'd35 * 64'd16777216 + 64'd50000000000)
    / 64'd100000000000;
  localparam longint CU_G =
    (64'd587 * 64'd493 * 64'd11447 * 64'd35 * 64'd16777216 + 64'd50000000000)
    / 64'd100000000000;
  localparam longint CV_G =
    (64'd587 * 64'd877 * 64'd8133 * 64'd35 * 64'd16777216 + 64'd50000000000)
    / 64'd100000000000;
  localparam longint CV_B =
    (64'd114 * 64'd877 * 64'd8133 * 64'd35 * 64'd16777216 + 64'd50000000000)
    / 64'd100000000000;
  // grey cancels exactly in both differences
  localparam longint CU_B = CU_R + CU_G;
  localparam longint CV_R = CV_G + CV_B;

  typedef struct packed {
    bit [7:0] blue;
    bit [7:0] green;
    bit [7:0] red;
    bit       line_end;
  } pixel_t;

  typedef struct packed {
    bit [9:0] luma;
    bit [9:0] blue_diff;
    bit [9:0] red_diff;
    bit       line_last;
  } yuv_t;

  typedef struct packed {
    bit       enable;
    bit [9:0] white;
    bit [9:0] black;
  } snap_cfg_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [7:0]         in_blue = '0;
  logic [7:0]         in_green = '0;
  logic [7:0]         in_red = '0;
  logic               in_line_end = 1'b0;
  logic               out_valid;
  logic [CODE_W-1:0]  out_luma;
  logic [CODE_W-1:0]  out_blue_diff;
  logic [CODE_W-1:0]  out_red_diff;
  logic               out_line_last;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  snap_cfg_t snap_cfg = '{enable: 1'b1, white: 10'd747, black: 10'd10};
  yuv_t      pending_yuv[$];
  int        mismatches = 0;
  longint    cycle_count = 0;

  rgb_to_yuv_10bit_converter_top i_dut (.*);

  always #2 clk = ~clk;

  function automatic logic [9:0] acc_to_code(input longint acc);
    longint code;
    code = (acc < 0) ? 0 : (acc >>> 24);
    if (code > 1023) code = 1023;
    return code[9:0];
  endfunction

  function automatic yuv_t convert_pixel(input pixel_t p, input snap_cfg_t c);
    longint b, g, r, sum;
    yuv_t   res;
    b = p.blue;
    g = p.green;
    r = p.red;
    sum = b + g + r;
    if (c.enable) begin
      if (sum > c.white) begin
        b = 255;
        g = 255;
        r = 255;
      end
      // black wins when both thresholds are hit
      if (sum < c.black) begin
        b = 0;
        g = 0;
        r = 0;
      end
    end
    res.luma      = acc_to_code(CY_R * r + CY_G * g + CY_B * b + 64 * ONE24);
    res.blue_diff = acc_to_code(CU_B * b - CU_R * r - CU_G * g + 512 * ONE24);
    res.red_diff  = acc_to_code(CV_R * r - CV_G * g - CV_B * b + 512 * ONE24);
    res.line_last = p.line_end;
    return res;
  endfunction

  function automatic pixel_t px(input int b, input int g, input int r, input bit le);
    return '{blue: b[7:0], green: g[7:0], red: r[7:0], line_end: le};
  endfunction

  // requests are taken at the edge where start is high and busy low
  always @(posedge clk) begin
    if (rst_n && start === 1'b1 && busy === 1'b0) begin
      pending_yuv.push_back(convert_pixel(
        '{blue: in_blue, green: in_green, red: in_red, line_end: in_line_end}, snap_cfg));
    end
  end

  always @(posedge clk) begin
    yuv_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_yuv.size() == 0) begin
        $error("unexpected result: luma %0d blue_diff %0d red_diff %0d line_last %0d",
               out_luma, out_blue_diff, out_red_diff, out_line_last);
        mismatches++;
      end else begin
        want = pending_yuv.pop_front();
        if (out_luma !== want.luma) begin
          $error("luma: expected %0d, got %0d", want.luma, out_luma);
          mismatches++;
        end
        if (out_blue_diff !== want.blue_diff) begin
          $error("blue_diff: expected %0d, got %0d", want.blue_diff, out_blue_diff);
          mismatches++;
        end
        if (out_red_diff !== want.red_diff) begin
          $error("red_diff: expected %0d, got %0d", want.red_diff, out_red_diff);
          mismatches++;
        end
        if (out_line_last !== want.line_last) begin
          $error("line_last: expected %0d, got %0d", want.line_last, out_line_last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_yuv.size());
      $display("rgb_to_yuv_10bit_converter_top test failed");
      $finish;
    end
  end

  task automatic send_pixel(input pixel_t p, input int idle_pct);
    bit taken;
    int gap;
    start       <= 1'b1;
    in_blue     <= p.blue;
    in_green    <= p.green;
    in_red      <= p.red;
    in_line_end <= p.line_end;
    do begin
      @(negedge clk);
      taken = (busy === 1'b0);
      @(posedge clk);
    end while (!taken);
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      // junk on the data lines while no request is pending
      start       <= 1'b0;
      in_blue     <= 8'($urandom);
      in_green    <= 8'($urandom);
      in_red      <= 8'($urandom);
      in_line_end <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_yuv.size() != 0);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] value);
    bit done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = (pready === 1'b1);
      @(posedge clk);
    end while (!done);
    case (idx)
      REG_ENABLE: snap_cfg.enable = value[0];
      REG_WHITE:  snap_cfg.white = value;
      REG_BLACK:  snap_cfg.black = value;
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_reg(input logic [1:0] idx, input logic [9:0] exp_val);
    bit          done;
    logic [31:0] data;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = (pready === 1'b1);
      data = prdata;
      @(posedge clk);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if ((idx == REG_ENABLE) ? (data[0] !== exp_val[0]) : (data[9:0] !== exp_val)) begin
      $error("prdata at 0x%0h: expected %0d, got %0d", {idx, 2'b00}, exp_val, data);
      mismatches++;
    end
  endtask

  task automatic set_snap(input bit en, input int white, input int black);
    wait_drained();
    write_reg(REG_ENABLE, 10'(en));
    write_reg(REG_WHITE, 10'(white));
    write_reg(REG_BLACK, 10'(black));
  endtask

  task automatic test_register_access();
    read_reg(REG_ENABLE, 10'd1);
    read_reg(REG_WHITE, WHITE_RST);
    read_reg(REG_BLACK, BLACK_RST);
    set_snap(1'b0, SUM_MAX, 0);
    read_reg(REG_ENABLE, 10'd0);
    read_reg(REG_WHITE, 10'(SUM_MAX));
    read_reg(REG_BLACK, 10'd0);
    set_snap(1'b1, 747, 10);
    read_reg(REG_ENABLE, 10'd1);
    read_reg(REG_WHITE, 10'd747);
    read_reg(REG_BLACK, 10'd10);
  endtask

  task automatic test_level_extremes();
    send_pixel(px(0, 0, 0, 1'b0), 0);
    send_pixel(px(255, 255, 255, 1'b1), 0);
    send_pixel(px(0, 0, 255, 1'b0), 0);
    send_pixel(px(0, 255, 0, 1'b0), 0);
    send_pixel(px(255, 0, 0, 1'b1), 0);
    send_pixel(px(255, 255, 0, 1'b0), 0);
    send_pixel(px(0, 255, 255, 1'b0), 0);
    send_pixel(px(255, 0, 255, 1'b0), 0);
    send_pixel(px(128, 128, 128, 1'b1), 0);
    // sums right at both snap thresholds
    send_pixel(px(249, 249, 249, 1'b0), 0);
    send_pixel(px(250, 249, 249, 1'b0), 0);
    send_pixel(px(4, 3, 3, 1'b0), 0);
    send_pixel(px(3, 3, 3, 1'b1), 0);
  endtask

  task automatic test_snap_disabled();
    set_snap(1'b0, 747, 10);
    send_pixel(px(3, 3, 3, 1'b0), 0);
    send_pixel(px(250, 249, 249, 1'b1), 0);
    send_pixel(px(254, 255, 253, 1'b0), 0);
    send_pixel(px(1, 0, 2, 1'b0), 0);
  endtask

  task automatic test_snap_overlap();
    // every sum between the thresholds hits both, black must win
    set_snap(1'b1, 0, SUM_MAX);
    send_pixel(px(1, 0, 0, 1'b0), 0);
    send_pixel(px(255, 255, 254, 1'b1), 0);
    send_pixel(px(255, 255, 255, 1'b0), 0);
    send_pixel(px(0, 0, 0, 1'b0), 0);
  endtask

  task automatic test_no_snap_window();
    set_snap(1'b1, SUM_MAX, 0);
    send_pixel(px(255, 255, 255, 1'b0), 0);
    send_pixel(px(0, 0, 0, 1'b1), 0);
    send_pixel(px(200, 17, 91, 1'b0), 0);
  endtask

  task automatic run_random_pixels(input int count, input int idle_pct);
    pixel_t p;
    int     kind, target, lo, hi, v;
    bit     by_sum;
    repeat (count) begin
      p = '{blue: 8'($urandom), green: 8'($urandom), red: 8'($urandom),
            line_end: ($urandom_range(0, 7) == 0)};
      kind = $urandom_range(0, 9);
      by_sum = 1'b0;
      target = 0;
      case (kind)
        5: begin
          p.blue  = 8'(255 - $urandom_range(0, 12));
          p.green = 8'(255 - $urandom_range(0, 12));
          p.red   = 8'(255 - $urandom_range(0, 12));
        end
        6: begin
          p.blue  = 8'($urandom_range(0, 6));
          p.green = 8'($urandom_range(0, 6));
          p.red   = 8'($urandom_range(0, 6));
        end
        7: begin
          v = $urandom_range(0, 255);
          p.blue  = 8'(v);
          p.green = 8'(v);
          p.red   = 8'(v);
        end
        8: begin
          by_sum = 1'b1;
          target = int'(snap_cfg.white) + int'($urandom_range(0, 2)) - 1;
        end
        9: begin
          by_sum = 1'b1;
          target = int'(snap_cfg.black) + int'($urandom_range(0, 2)) - 1;
        end
        default: ;
      endcase
      // split a sum at or beside a threshold over the three channels
      if (by_sum) begin
        if (target < 0) target = 0;
        if (target > SUM_MAX) target = SUM_MAX;
        lo = (target > 510) ? target - 510 : 0;
        hi = (target > 255) ? 255 : target;
        v = $urandom_range(hi, lo);
        p.red = 8'(v);
        target -= v;
        lo = (target > 255) ? target - 255 : 0;
        hi = (target > 255) ? 255 : target;
        v = $urandom_range(hi, lo);
        p.green = 8'(v);
        p.blue = 8'(target - v);
      end
      send_pixel(p, idle_pct);
    end
  endtask

  task automatic test_random_reset_cfg();
    set_snap(1'b1, 747, 10);
    run_random_pixels(150, 0);
  endtask

  task automatic test_random_thresholds();
    repeat (5) begin
      set_snap(1'b1, $urandom_range(0, SUM_MAX), $urandom_range(0, SUM_MAX));
      run_random_pixels(25, 87);
    end
  endtask

  task automatic test_random_snap_off();
    set_snap(1'b0, 300, 400);
    run_random_pixels(125, 20);
  endtask

  task automatic test_random_wide_snap();
    set_snap(1'b1, 600, 150);
    run_random_pixels(125, 0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_level_extremes();
    test_snap_disabled();
    test_snap_overlap();
    test_no_snap_window();
    test_random_reset_cfg();
    test_random_thresholds();
    test_random_snap_off();
    test_random_wide_snap();
    wait_drained();
    if (mismatches == 0) begin
      $display("rgb_to_yuv_10bit_converter_top test passed");
    end else begin
      $display("rgb_to_yuv_10bit_converter_top test failed");
    end
    $finish;
  end

endmodule
